// ===== rtl/qarma64_pkg.sv =====
package qarma64_pkg;

  // Basic types: one 64-bit block of sixteen cells, cell 0 in bits 63..60.
  typedef logic [63:0] block_t;
  typedef logic [3:0]  nibble_t;

  // Register map, one 64-bit register every eight bytes.
  typedef enum logic [1:0] {
    RegWhitening = 2'd0,
    RegCore      = 2'd1,
    RegRounds    = 2'd2,
    RegSbox      = 2'd3
  } reg_idx_e;

  // Operation carried by each input beat.
  typedef enum logic {
    CmdEncrypt = 1'b0,
    CmdDecrypt = 1'b1
  } cmd_e;

  localparam int unsigned MaxRounds = 8;
  localparam int unsigned NumCells  = 16;

  localparam logic [3:0] RoundsReset = 4'd7;
  localparam logic [1:0] SboxReset   = 2'd2;
  localparam logic [1:0] SboxLast    = 2'd2;

  localparam block_t Alpha = 64'hC0AC29B7C97C50DD;

  localparam logic [0:MaxRounds-1][63:0] RoundConst = {
    64'h0000000000000000, 64'h13198A2E03707344, 64'hA4093822299F31D0,
    64'h082EFA98EC4E6C89, 64'h452821E638D01377, 64'hBE5466CF34E90C6C,
    64'h3F84D5B5B5470917, 64'h9216D5D98979FB1B
  };

  localparam logic [0:2][0:15][3:0] SboxFwd = {
    {4'd0, 4'd14, 4'd2, 4'd10, 4'd9, 4'd15, 4'd8, 4'd11,
     4'd6, 4'd4, 4'd3, 4'd7, 4'd13, 4'd12, 4'd1, 4'd5},
    {4'd10, 4'd13, 4'd14, 4'd6, 4'd15, 4'd7, 4'd3, 4'd5,
     4'd9, 4'd8, 4'd0, 4'd12, 4'd11, 4'd1, 4'd2, 4'd4},
    {4'd11, 4'd6, 4'd8, 4'd15, 4'd12, 4'd0, 4'd9, 4'd14,
     4'd3, 4'd7, 4'd4, 4'd5, 4'd13, 4'd2, 4'd1, 4'd10}
  };

  localparam logic [0:2][0:15][3:0] SboxInv = {
    {4'd0, 4'd14, 4'd2, 4'd10, 4'd9, 4'd15, 4'd8, 4'd11,
     4'd6, 4'd4, 4'd3, 4'd7, 4'd13, 4'd12, 4'd1, 4'd5},
    {4'd10, 4'd13, 4'd14, 4'd6, 4'd15, 4'd7, 4'd3, 4'd5,
     4'd9, 4'd8, 4'd0, 4'd12, 4'd11, 4'd1, 4'd2, 4'd4},
    {4'd5, 4'd14, 4'd13, 4'd8, 4'd10, 4'd11, 4'd1, 4'd9,
     4'd2, 4'd6, 4'd15, 4'd0, 4'd4, 4'd12, 4'd7, 4'd3}
  };

  // Cell shuffles: output cell i takes input cell perm[i].
  localparam logic [0:15][3:0] PermTau = {
    4'd0, 4'd11, 4'd6, 4'd13, 4'd10, 4'd1, 4'd12, 4'd7,
    4'd5, 4'd14, 4'd3, 4'd8, 4'd15, 4'd4, 4'd9, 4'd2
  };
  localparam logic [0:15][3:0] PermTauInv = {
    4'd0, 4'd5, 4'd15, 4'd10, 4'd13, 4'd8, 4'd2, 4'd7,
    4'd11, 4'd14, 4'd4, 4'd1, 4'd6, 4'd3, 4'd9, 4'd12
  };
  localparam logic [0:15][3:0] PermH = {
    4'd6, 4'd5, 4'd14, 4'd15, 4'd0, 4'd1, 4'd2, 4'd3,
    4'd7, 4'd12, 4'd13, 4'd4, 4'd8, 4'd9, 4'd10, 4'd11
  };
  localparam logic [0:15][3:0] PermHInv = {
    4'd4, 4'd5, 4'd6, 4'd7, 4'd11, 4'd1, 4'd0, 4'd8,
    4'd12, 4'd13, 4'd14, 4'd15, 4'd9, 4'd10, 4'd2, 4'd3
  };

  // Rotation amounts of the MixColumns matrix; zero means no term.
  localparam logic [0:15][1:0] MixRot = {
    2'd0, 2'd1, 2'd2, 2'd1, 2'd1, 2'd0, 2'd1, 2'd2,
    2'd2, 2'd1, 2'd0, 2'd1, 2'd1, 2'd2, 2'd1, 2'd0
  };

  // Tweak cells that pass through the cell LFSR, bit k for cell k.
  localparam logic [15:0] LfsrCells = 16'h291B;

  function automatic nibble_t get_cell(block_t v, int unsigned k);
    return v[(63 - 4 * k) -: 4];
  endfunction

  function automatic block_t permute(block_t v, logic [0:15][3:0] perm);
    block_t r;
    r = '0;
    for (int unsigned i = 0; i < NumCells; i++) begin
      r[(63 - 4 * i) -: 4] = get_cell(v, int'(perm[i]));
    end
    return r;
  endfunction

  function automatic nibble_t rot_cell(nibble_t a, logic [1:0] b);
    nibble_t r;
    case (b)
      2'd1:    r = {a[2:0], a[3]};
      2'd2:    r = {a[1:0], a[3:2]};
      default: r = 4'h0;
    endcase
    return r;
  endfunction

  function automatic block_t mix_columns(block_t v);
    block_t  r;
    nibble_t acc;
    r = '0;
    for (int unsigned x = 0; x < 4; x++) begin
      for (int unsigned y = 0; y < 4; y++) begin
        acc = 4'h0;
        for (int unsigned j = 0; j < 4; j++) begin
          acc = acc ^ rot_cell(get_cell(v, 4 * j + y), MixRot[4 * x + j]);
        end
        r[(63 - 4 * (4 * x + y)) -: 4] = acc;
      end
    end
    return r;
  endfunction

  function automatic block_t sub_cells(block_t v, logic [1:0] sb, logic inv);
    block_t  r;
    nibble_t c;
    r = '0;
    for (int unsigned k = 0; k < NumCells; k++) begin
      c = get_cell(v, k);
      r[(63 - 4 * k) -: 4] = inv ? SboxInv[sb][c] : SboxFwd[sb][c];
    end
    return r;
  endfunction

  function automatic nibble_t lfsr_fwd(nibble_t x);
    return {x[0] ^ x[1], x[3], x[2], x[1]};
  endfunction

  function automatic nibble_t lfsr_bwd(nibble_t x);
    return {x[2], x[1], x[0], x[0] ^ x[3]};
  endfunction

  function automatic block_t tweak_fwd(block_t t);
    block_t p;
    p = permute(t, PermH);
    for (int unsigned k = 0; k < NumCells; k++) begin
      if (LfsrCells[k]) begin
        p[(63 - 4 * k) -: 4] = lfsr_fwd(get_cell(p, k));
      end
    end
    return p;
  endfunction

  function automatic block_t tweak_bwd(block_t t);
    block_t c;
    c = t;
    for (int unsigned k = 0; k < NumCells; k++) begin
      if (LfsrCells[k]) begin
        c[(63 - 4 * k) -: 4] = lfsr_bwd(get_cell(c, k));
      end
    end
    return permute(c, PermHInv);
  endfunction

  function automatic block_t ortho(block_t w);
    return {w[0], w[63:1]} ^ {63'b0, w[63]};
  endfunction

  function automatic block_t round_fwd(block_t s, block_t tk, logic full, logic [1:0] sb);
    block_t c;
    c = s ^ tk;
    if (full) begin
      c = mix_columns(permute(c, PermTau));
    end
    return sub_cells(c, sb, 1'b0);
  endfunction

  function automatic block_t round_bwd(block_t s, block_t tk, logic full, logic [1:0] sb);
    block_t c;
    c = sub_cells(s, sb, 1'b1);
    if (full) begin
      c = permute(mix_columns(c), PermTauInv);
    end
    return c ^ tk;
  endfunction

  function automatic block_t reflector(block_t s, block_t tk);
    return permute(mix_columns(permute(s, PermTau)) ^ tk, PermTauInv);
  endfunction

endpackage

// ===== rtl/qarma64_core.sv =====
// Full QARMA-64 datapath for one block, forward rounds, reflector and
// backward rounds. Rounds beyond the configured count pass the state through.
module qarma64_core (
  input  logic        command_i,
  input  logic [63:0] text_i,
  input  logic [63:0] tweak_i,
  input  logic [63:0] key_whitening_i,
  input  logic [63:0] key_core_i,
  input  logic [3:0]  round_count_i,
  input  logic [1:0]  sbox_select_i,
  output logic [63:0] text_o
);

  localparam int unsigned NR = qarma64_pkg::MaxRounds;

  logic [3:0]  nr_sat;
  logic [1:0]  sb_sat;
  logic [63:0] w0, w1, k0, k1;
  logic [63:0] st_f [NR+1];
  logic [63:0] tw_f [NR+1];
  logic [63:0] st_b [NR+1];
  logic [63:0] tw_b [NR+1];
  logic [63:0] center;

  // Saturate the round count and the S-box choice.
  assign nr_sat = (round_count_i > 4'(NR)) ? 4'(NR) : round_count_i;
  assign sb_sat = (sbox_select_i > qarma64_pkg::SboxLast) ? qarma64_pkg::SboxLast
                                                          : sbox_select_i;

  // Key schedule: decryption swaps the whitening keys and adjusts the core keys.
  always_comb begin
    if (command_i == qarma64_pkg::CmdDecrypt) begin
      w0 = qarma64_pkg::ortho(key_whitening_i);
      w1 = key_whitening_i;
      k0 = key_core_i ^ qarma64_pkg::Alpha;
      k1 = qarma64_pkg::mix_columns(key_core_i);
    end else begin
      w0 = key_whitening_i;
      w1 = qarma64_pkg::ortho(key_whitening_i);
      k0 = key_core_i;
      k1 = key_core_i;
    end
  end

  assign st_f[0] = text_i ^ w0;
  assign tw_f[0] = tweak_i;

  // Forward rounds; the first one skips ShuffleCells and MixColumns.
  for (genvar i = 0; i < NR; i++) begin : g_fwd
    logic on;
    assign on = nr_sat > 4'(i);
    assign st_f[i+1] = on ? qarma64_pkg::round_fwd(st_f[i],
                                k0 ^ tw_f[i] ^ qarma64_pkg::RoundConst[i],
                                1'(i != 0), sb_sat)
                          : st_f[i];
    assign tw_f[i+1] = on ? qarma64_pkg::tweak_fwd(tw_f[i]) : tw_f[i];
  end

  // Central forward round, pseudo-reflector and central backward round.
  always_comb begin
    center = qarma64_pkg::round_fwd(st_f[NR], w1 ^ tw_f[NR], 1'b1, sb_sat);
    center = qarma64_pkg::reflector(center, k1);
    center = qarma64_pkg::round_bwd(center, w0 ^ tw_f[NR], 1'b1, sb_sat);
  end

  assign st_b[0] = center;
  assign tw_b[0] = tw_f[NR];

  // Backward rounds in reverse order; step j undoes forward round NR-1-j.
  for (genvar j = 0; j < NR; j++) begin : g_bwd
    localparam int unsigned Rnd = NR - 1 - j;
    logic        on;
    logic [63:0] tw_prev;
    assign on      = nr_sat > 4'(Rnd);
    assign tw_prev = qarma64_pkg::tweak_bwd(tw_b[j]);
    assign tw_b[j+1] = on ? tw_prev : tw_b[j];
    assign st_b[j+1] = on ? qarma64_pkg::round_bwd(st_b[j],
                                k0 ^ tw_prev ^ qarma64_pkg::RoundConst[Rnd] ^
                                qarma64_pkg::Alpha,
                                1'(Rnd != 0), sb_sat)
                          : st_b[j];
  end

  assign text_o = st_b[NR] ^ w1;

endmodule

// ===== rtl/qarma64_block_cipher.sv =====
// QARMA-64 tweakable block cipher.
// Input channel (in_valid_i / in_ready_o) carries one beat per block: the
// command (0 encrypt, 1 decrypt), the 64-bit text and the 64-bit tweak.
// Output channel (out_valid_o / out_ready_i) returns one beat per block with
// the 64-bit result, in the order the blocks were taken.
// Keys, round count and S-box choice are set over the APB port, one 64-bit
// register every eight bytes; write them only while no block is in flight.
// The input register holds each taken beat, the cipher runs on it in one
// combinational pass, and the result register loads the result when the
// input register moves on. Throughput is one block per cycle while the
// receiver takes the results; the cycle time is set by the full cipher pass
// from the input register to the result register.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more block; after that in_ready_o drops.
// Reset empties both registers and loads the register defaults: both keys
// zero, seven rounds, the third S-box.
module qarma64_block_cipher (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [63:0] text_in_i,
  input  logic [63:0] tweak_in_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] text_out_o
);

  logic [63:0] key_whitening_q, key_core_q;
  logic [3:0]  round_count_q;
  logic [1:0]  sbox_select_q;
  logic        cfg_write;
  qarma64_pkg::reg_idx_e cfg_idx;

  logic        s1_valid_q;
  logic        s1_cmd_q;
  logic [63:0] s1_text_q, s1_tweak_q;
  logic        s1_adv;
  logic        in_take;
  logic        out_valid_q;
  logic [63:0] out_text_q;
  logic [63:0] core_text;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;
  assign cfg_idx   = qarma64_pkg::reg_idx_e'(paddr[4:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_whitening_q <= '0;
      key_core_q      <= '0;
      round_count_q   <= qarma64_pkg::RoundsReset;
      sbox_select_q   <= qarma64_pkg::SboxReset;
    end else if (cfg_write) begin
      case (cfg_idx)
        qarma64_pkg::RegWhitening: key_whitening_q <= pwdata;
        qarma64_pkg::RegCore:      key_core_q      <= pwdata;
        qarma64_pkg::RegRounds:    round_count_q   <= pwdata[3:0];
        qarma64_pkg::RegSbox:      sbox_select_q   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_idx)
      qarma64_pkg::RegWhitening: prdata = key_whitening_q;
      qarma64_pkg::RegCore:      prdata = key_core_q;
      qarma64_pkg::RegRounds:    prdata = {60'b0, round_count_q};
      qarma64_pkg::RegSbox:      prdata = {62'b0, sbox_select_q};
      default:                   prdata = '0;
    endcase
  end

  // Flow control: the input register moves on whenever the result register
  // is empty or its beat is being taken.
  assign s1_adv     = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_take    = in_valid_i && in_ready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_cmd_q   <= command_i;
      s1_text_q  <= text_in_i;
      s1_tweak_q <= tweak_in_i;
    end
  end

  // Cipher datapath.
  qarma64_core u_core (
    .command_i       (s1_cmd_q),
    .text_i          (s1_text_q),
    .tweak_i         (s1_tweak_q),
    .key_whitening_i (key_whitening_q),
    .key_core_i      (key_core_q),
    .round_count_i   (round_count_q),
    .sbox_select_i   (sbox_select_q),
    .text_o          (core_text)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_text_q <= core_text;
    end
  end

  assign out_valid_o = out_valid_q;
  assign text_out_o  = out_text_q;

  // A block waiting in the input register stays there unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_text_q) && $stable(s1_tweak_q)))
    else $error("input register lost or changed a stalled block");

  // An empty result register never blocks the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled while result register empty");

  // A taken input beat lands in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("accepted block missing from input register");

  // A block leaving the input register becomes a result beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_adv) |=> out_valid_q)
    else $error("block dropped between input and result registers");

endmodule
